// ===== hw/rtl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types and constants for the servo PWM controller.
// ----------------------------------------------------------------------------
package svpwm_pkg;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [5:0] ADDR_DISABLE = 6'h30;

   localparam logic [7:0] PULSE_MIN   = 8'd50;
   localparam logic [7:0] PULSE_MAX   = 8'd250;
   localparam logic [7:0] ANGLE_MAX   = 8'd180;
   localparam logic [7:0] ANGLE_UNSET = 8'hFF;

   // reciprocals: x/9 = (x*7282)>>16 for x <= 1800, x/10 = (x*6554)>>16
   // for x <= 1800, x/10 = (x*52429)>>19 for any 16-bit x
   localparam logic [23:0] RECIP_NINTH    = 24'd7282;
   localparam logic [23:0] RECIP_TENTH_16 = 24'd6554;
   localparam logic [31:0] RECIP_TENTH_19 = 32'd52429;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      CMD_NOP         = 3'd0,
      CMD_TICK        = 3'd1,
      CMD_SET_ANGLE   = 3'd2,
      CMD_SET_PULSE   = 3'd3,
      CMD_SET_DISABLE = 3'd4,
      CMD_RD_ANGLE    = 3'd5,
      CMD_RD_PULSE    = 3'd6,
      CMD_RD_DISABLE  = 3'd7
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   ch;
      logic [7:0]   angle;
      logic [7:0]   pulse;
      logic         dis;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

// ===== hw/rtl/svpwm_front.sv =====
// ----------------------------------------------------------------------------
// svpwm_front
// Decodes a request word into a command and precomputes pulse widths.
// ----------------------------------------------------------------------------
module svpwm_front #(
   parameter int CHANNELS = 8
) (
   input  logic [1:0]         req_kind,
   input  logic [5:0]         reg_address,
   input  logic [15:0]        write_data,
   output svpwm_pkg::cmd_type cmd
);

   logic [10:0] ang_x;
   logic [23:0] ang_prod;
   logic [31:0] us_prod;
   logic [12:0] ticks;
   logic [3:0]  ach;
   logic [3:0]  pch;
   logic        ang_hit;
   logic        pls_hit;
   logic        dis_hit;
   logic        ang_ok;
   logic        pls_ok;

   assign ang_x    = {write_data[7:0], 3'b000} + {2'b00, write_data[7:0], 1'b0};
   assign ang_prod = {13'd0, ang_x} * svpwm_pkg::RECIP_NINTH;
   assign us_prod  = {16'd0, write_data} * svpwm_pkg::RECIP_TENTH_19;
   assign ticks    = us_prod[31:19];

   assign ach     = {1'b0, reg_address[2:0]};
   assign pch     = {1'b0, reg_address[3:1]};
   assign ang_hit = (reg_address[5:3] == 3'b000) && (ach < 4'(CHANNELS));
   assign pls_hit = (reg_address[5:4] == 2'b01) && !reg_address[0] && (pch < 4'(CHANNELS));
   assign dis_hit = (reg_address == svpwm_pkg::ADDR_DISABLE);
   assign ang_ok  = (write_data <= {8'd0, svpwm_pkg::ANGLE_MAX});
   assign pls_ok  = (ticks >= {5'd0, svpwm_pkg::PULSE_MIN}) &&
                    (ticks <= {5'd0, svpwm_pkg::PULSE_MAX});

   always_comb begin
      cmd.ch    = ang_hit ? reg_address[2:0] : reg_address[3:1];
      cmd.angle = write_data[7:0];
      cmd.pulse = ang_hit ? (svpwm_pkg::PULSE_MIN + ang_prod[23:16]) : ticks[7:0];
      cmd.dis   = write_data[0];
      unique case (req_kind)
         svpwm_pkg::REQ_TICK: begin
            cmd.kind = svpwm_pkg::CMD_TICK;
         end
         svpwm_pkg::REQ_WRITE: begin
            priority if (ang_hit) begin
               cmd.kind = ang_ok ? svpwm_pkg::CMD_SET_ANGLE : svpwm_pkg::CMD_NOP;
            end else if (pls_hit) begin
               cmd.kind = pls_ok ? svpwm_pkg::CMD_SET_PULSE : svpwm_pkg::CMD_NOP;
            end else if (dis_hit) begin
               cmd.kind = svpwm_pkg::CMD_SET_DISABLE;
            end else begin
               cmd.kind = svpwm_pkg::CMD_NOP;
            end
         end
         svpwm_pkg::REQ_READ: begin
            priority if (ang_hit) begin
               cmd.kind = svpwm_pkg::CMD_RD_ANGLE;
            end else if (pls_hit) begin
               cmd.kind = svpwm_pkg::CMD_RD_PULSE;
            end else if (dis_hit) begin
               cmd.kind = svpwm_pkg::CMD_RD_DISABLE;
            end else begin
               cmd.kind = svpwm_pkg::CMD_NOP;
            end
         end
         default: begin
            cmd.kind = svpwm_pkg::CMD_NOP;
         end
      endcase
   end

endmodule

// ===== hw/rtl/svpwm_queue.sv =====
// ----------------------------------------------------------------------------
// svpwm_queue
// Two-entry command queue between decode and execute.
// ----------------------------------------------------------------------------
module svpwm_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  svpwm_pkg::cmd_type          push_cmd,
   input  logic                        pop,
   output svpwm_pkg::cmd_type          head_cmd,
   output svpwm_pkg::queue_status_type status
);

   svpwm_pkg::cmd_type entry_ff [svpwm_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'(svpwm_pkg::QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/svpwm_back.sv =====
// ----------------------------------------------------------------------------
// svpwm_back
// Executes commands against channel state and registers the response word.
// ----------------------------------------------------------------------------
module svpwm_back #(
   parameter int CHANNELS     = 8,
   parameter int PERIOD_TICKS = 2000
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  svpwm_pkg::cmd_type cmd,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata  // read_data[11:0], pwm_outputs[19:12], power_off[20]
);

   logic [7:0]  angle_ff [CHANNELS];
   logic [7:0]  angle_in [CHANNELS];
   logic [7:0]  pulse_ff [CHANNELS];
   logic [7:0]  pulse_in [CHANNELS];
   logic        dis_ff;
   logic        dis_in;
   logic [10:0] cnt_ff;
   logic [10:0] cnt_in;
   logic [11:0] cnt_inc;
   logic [7:0]  y;
   logic [10:0] y9;
   logic [23:0] conv_prod;
   logic [7:0]  conv_angle;
   logic [7:0]  pwm;
   logic [7:0]  sel_angle;
   logic [7:0]  sel_pulse;
   logic [11:0] rd;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [23:0] rsp_data_ff;

   assign pop        = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign y          = cmd.pulse - svpwm_pkg::PULSE_MIN;
   assign y9         = {y, 3'b000} + {3'b000, y};
   assign conv_prod  = {13'd0, y9} * svpwm_pkg::RECIP_TENTH_16;
   assign conv_angle = conv_prod[23:16];
   assign cnt_inc    = {1'b0, cnt_ff} + 12'd1;

   always_comb begin
      cnt_in = cnt_ff;
      dis_in = dis_ff;
      if (pop && (cmd.kind == svpwm_pkg::CMD_TICK)) begin
         cnt_in = (cnt_inc >= 12'(PERIOD_TICKS)) ? 11'd0 : cnt_inc[10:0];
      end
      if (pop && (cmd.kind == svpwm_pkg::CMD_SET_DISABLE)) begin
         dis_in = cmd.dis;
      end
   end

   always_comb begin
      sel_angle = 8'd0;
      sel_pulse = 8'd0;
      pwm       = 8'd0;
      for (int i = 0; i < CHANNELS; i++) begin
         angle_in[i] = angle_ff[i];
         pulse_in[i] = pulse_ff[i];
         if (pop && (cmd.ch == 3'(i))) begin
            if (cmd.kind == svpwm_pkg::CMD_SET_ANGLE) begin
               angle_in[i] = cmd.angle;
               pulse_in[i] = cmd.pulse;
            end else if (cmd.kind == svpwm_pkg::CMD_SET_PULSE) begin
               angle_in[i] = conv_angle;
               pulse_in[i] = cmd.pulse;
            end
         end
         if (cmd.ch == 3'(i)) begin
            sel_angle = angle_ff[i];
            sel_pulse = pulse_ff[i];
         end
         pwm[i] = (cnt_in <= {3'b000, pulse_in[i]});
      end
   end

   always_comb begin
      unique case (cmd.kind)
         svpwm_pkg::CMD_RD_ANGLE:   rd = {4'd0, sel_angle};
         svpwm_pkg::CMD_RD_PULSE:   rd = {1'b0, sel_pulse, 3'b000} + {3'b000, sel_pulse, 1'b0};
         svpwm_pkg::CMD_RD_DISABLE: rd = {11'd0, dis_ff};
         default:                   rd = 12'd0;
      endcase
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= {3'b000, dis_in, pwm, rd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         dis_ff       <= 1'b0;
         cnt_ff       <= 11'd0;
         for (int i = 0; i < CHANNELS; i++) begin
            angle_ff[i] <= svpwm_pkg::ANGLE_UNSET;
            pulse_ff[i] <= 8'd0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         dis_ff       <= dis_in;
         cnt_ff       <= cnt_in;
         for (int i = 0; i < CHANNELS; i++) begin
            angle_ff[i] <= angle_in[i];
            pulse_ff[i] <= pulse_in[i];
         end
      end
   end

endmodule

// ===== hw/rtl/servo_pwm_controller_core.sv =====
// ----------------------------------------------------------------------------
// servo_pwm_controller_core
// Eight-channel servo PWM generator with a small register map.
// ----------------------------------------------------------------------------
// Each request word (tick, register write or register read) yields one
// response word carrying the read value, the PWM levels after the request and
// the power-disable bit. A new request is taken every cycle while the queue
// is not full; a response passes through the decode stage, a two-word command
// queue and the registered response stage. The queue and the response register
// let the request side keep going while a response waits.
module servo_pwm_controller_core #(
   parameter int CHANNELS     = 8,
   parameter int PERIOD_TICKS = 2000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // reg_address[5:0], write_data[21:6]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_data[11:0], pwm_outputs[19:12], power_off[20]
);

   svpwm_pkg::cmd_type          dec_cmd;
   svpwm_pkg::cmd_type          head_cmd;
   svpwm_pkg::queue_status_type q_stat;
   logic                        push;
   logic                        pop;

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   svpwm_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .req_kind    (req_tuser),
      .reg_address (req_tdata[5:0]),
      .write_data  (req_tdata[21:6]),
      .cmd         (dec_cmd)
   );

   svpwm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (dec_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_stat)
   );

   svpwm_back #(
      .CHANNELS     (CHANNELS),
      .PERIOD_TICKS (PERIOD_TICKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_stat.valid),
      .cmd        (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_pwm_unused_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[19:12] >> CHANNELS) == 8'd0))
      else $error("pwm bit set for unused channel");

   a_read_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:0] <= 12'd2500))
      else $error("read value out of range");

   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(q_stat.valid))
      else $error("response without queued command");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("push into full queue");

endmodule
